>>> rtl/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg
// Shared constants, types and helper functions for the look-angle pipeline.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 16;

  localparam int FRAC_BITS  = 24;
  localparam int TABLE_LEN  = 24;
  localparam int NUM_STAGES = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int IN_W    = 16;
  localparam int YAW_W   = 12;
  localparam int PITCH_W = 11;

  // Datapath: Q24 coordinates plus headroom for two passes of CORDIC growth.
  localparam int DW = COORD_WIDTH + FRAC_BITS + 4;
  // Angle: 2^32 counts per turn, plus sign and overshoot headroom.
  localparam int AW = 34;
  // Gain in Q30, and the signed product z * gain.
  localparam int KW = 32;
  localparam int PW = COORD_WIDTH + KW + 1;
  localparam int GAIN_SHIFT = 30 - FRAC_BITS;

  localparam int TENTHS_PER_TURN = 3600;
  localparam int TW = AW + 12 - 32;

  localparam logic [YAW_W-1:0] YAW_LIMIT   = YAW_W'(1800);
  localparam logic [YAW_W-1:0] PITCH_LIMIT = YAW_W'(900);
  localparam logic [YAW_W-1:0] QUARTER     = YAW_W'(900);

  typedef logic signed [DW-1:0]      vec_t;
  typedef logic signed [AW-1:0]      angle_t;
  typedef logic signed [YAW_W-1:0]   yaw_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;

  localparam angle_t HALF_TURN = AW'(64'sd2147483648);

  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic x_neg;
    logic y_pos;
    logic z_zero;
    logic z_pos;
  } flags_t;

  typedef struct packed {
    flags_t f;
    vec_t   gz;
    yaw_t   yaw;
  } side_t;

  // atan(2^-i) in counts of 2^32 per turn, rounded.
  function automatic angle_t atan_count(input int i);
    angle_t v;
    case (i)
      0:       v = AW'(64'd536870912);
      1:       v = AW'(64'd316933406);
      2:       v = AW'(64'd167458907);
      3:       v = AW'(64'd85004756);
      4:       v = AW'(64'd42667331);
      5:       v = AW'(64'd21354465);
      6:       v = AW'(64'd10679838);
      7:       v = AW'(64'd5340245);
      8:       v = AW'(64'd2670163);
      9:       v = AW'(64'd1335087);
      10:      v = AW'(64'd667544);
      11:      v = AW'(64'd333772);
      12:      v = AW'(64'd166886);
      13:      v = AW'(64'd83443);
      14:      v = AW'(64'd41722);
      15:      v = AW'(64'd20861);
      16:      v = AW'(64'd10430);
      17:      v = AW'(64'd5215);
      18:      v = AW'(64'd2608);
      19:      v = AW'(64'd1304);
      20:      v = AW'(64'd652);
      21:      v = AW'(64'd326);
      22:      v = AW'(64'd163);
      23:      v = AW'(64'd81);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Floor square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC gain in Q30 over the stages used.
  function automatic logic [63:0] gain_q30();
    logic [63:0] k2;
    k2 = 64'd1 << 60;
    for (int i = 0; i < NUM_STAGES; i++) k2 = k2 + (k2 >> (2 * i));
    return isqrt64(k2);
  endfunction

  localparam logic [KW-1:0] GAIN_Q30 = KW'(gain_q30());

  // Sign-extend a coordinate from COORD_WIDTH bits and place it in Q24.
  function automatic vec_t coord_q(input logic [IN_W-1:0] raw);
    logic signed [COORD_WIDTH-1:0] c;
    vec_t                          e;
    c = COORD_WIDTH'(raw);
    e = DW'(c);
    return e <<< FRAC_BITS;
  endfunction

  // Angle counts to tenths of a degree, truncated toward zero and saturated.
  function automatic yaw_t to_tenths(input angle_t a, input logic [YAW_W-1:0] limit);
    logic [AW-1:0]    mag;
    logic [AW+11:0]   prod;
    logic [TW-1:0]    t;
    logic [YAW_W-1:0] ts;
    mag  = a[AW-1] ? unsigned'(-a) : unsigned'(a);
    prod = (AW + 12)'(mag) * (AW + 12)'(TENTHS_PER_TURN);
    t    = prod[AW+11:32];
    if (t > TW'(limit)) ts = limit;
    else                ts = t[YAW_W-1:0];
    return a[AW-1] ? -signed'(ts) : signed'(ts);
  endfunction

endpackage

>>> rtl/pla_front.sv
// ----------------------------------------------------------------------------
// pla_front
// Input conditioning: left-half-plane fold, edge flags, and z times gain.
// ----------------------------------------------------------------------------
module pla_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pla_pkg::IN_W-1:0]   in_point_x,
  input  logic [pla_pkg::IN_W-1:0]   in_point_y,
  input  logic [pla_pkg::IN_W-1:0]   in_point_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pla_pkg::vec_t              out_x,
  output pla_pkg::vec_t              out_y,
  output pla_pkg::angle_t            out_a,
  output pla_pkg::side_t             out_side
);
  import pla_pkg::*;

  vec_t   x_c, y_c, z_c, xa_nxt, ya_nxt;
  angle_t a_nxt;
  flags_t f_nxt;

  logic   va_r, vb_r, rdy_a, rdy_b;
  vec_t   xa_r, ya_r, xb_r, yb_r;
  angle_t aa_r, ab_r;
  flags_t fa_r, fb_r;
  logic signed [COORD_WIDTH-1:0] za_r;
  logic signed [PW-1:0]          prod_nxt, prod_r;

  assign x_c = coord_q(in_point_x);
  assign y_c = coord_q(in_point_y);
  assign z_c = coord_q(in_point_z);

  always_comb begin
    f_nxt.y_zero = (y_c == '0);
    f_nxt.x_zero = (x_c == '0);
    f_nxt.x_neg  = x_c[DW-1];
    f_nxt.y_pos  = !y_c[DW-1] && (y_c != '0);
    f_nxt.z_zero = (z_c == '0);
    f_nxt.z_pos  = !z_c[DW-1] && (z_c != '0);
    if (x_c[DW-1]) begin
      xa_nxt = -x_c;
      ya_nxt = -y_c;
      a_nxt  = y_c[DW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      xa_nxt = x_c;
      ya_nxt = y_c;
      a_nxt  = '0;
    end
  end

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  assign prod_nxt = PW'(za_r) * PW'(signed'({1'b0, GAIN_Q30}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
    if (rdy_a && in_valid) begin
      xa_r <= xa_nxt;
      ya_r <= ya_nxt;
      aa_r <= a_nxt;
      fa_r <= f_nxt;
      za_r <= COORD_WIDTH'(z_c >>> FRAC_BITS);
    end
    if (rdy_b && va_r) begin
      xb_r   <= xa_r;
      yb_r   <= ya_r;
      ab_r   <= aa_r;
      fb_r   <= fa_r;
      prod_r <= prod_nxt;
    end
  end

  assign out_valid    = vb_r;
  assign out_x        = xb_r;
  assign out_y        = yb_r;
  assign out_a        = ab_r;
  assign out_side.f   = fb_r;
  assign out_side.gz  = DW'(prod_r >>> GAIN_SHIFT);
  assign out_side.yaw = '0;

endmodule

>>> rtl/pla_cordic_pass.sv
// ----------------------------------------------------------------------------
// pla_cordic_pass
// One full CORDIC vectoring pass, one registered stage per iteration.
// ----------------------------------------------------------------------------
module pla_cordic_pass (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pla_pkg::vec_t   in_x,
  input  pla_pkg::vec_t   in_y,
  input  pla_pkg::angle_t in_a,
  input  pla_pkg::side_t  in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output pla_pkg::vec_t   out_x,
  output pla_pkg::vec_t   out_y,
  output pla_pkg::angle_t out_a,
  output pla_pkg::side_t  out_side
);
  import pla_pkg::*;

  logic   sv [NUM_STAGES+1];
  logic   rdy[NUM_STAGES+1];
  vec_t   sx [NUM_STAGES+1];
  vec_t   sy [NUM_STAGES+1];
  angle_t sa [NUM_STAGES+1];
  side_t  ss [NUM_STAGES+1];

  assign sv[0] = in_valid;
  assign sx[0] = in_x;
  assign sy[0] = in_y;
  assign sa[0] = in_a;
  assign ss[0] = in_side;
  assign rdy[NUM_STAGES] = out_ready;

  for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
    localparam angle_t ATAN_I = atan_count(i);
    logic   v_r;
    vec_t   x_r, y_r, x_nxt, y_nxt, dx, dy;
    angle_t a_r, a_nxt;
    side_t  s_r;

    assign dx = sy[i] >>> i;
    assign dy = sx[i] >>> i;

    // Rotate toward the x axis: sign of y picks the direction.
    always_comb begin
      if (!sy[i][DW-1]) begin
        x_nxt = sx[i] + dx;
        y_nxt = sy[i] - dy;
        a_nxt = sa[i] + ATAN_I;
      end else begin
        x_nxt = sx[i] - dx;
        y_nxt = sy[i] + dy;
        a_nxt = sa[i] - ATAN_I;
      end
    end

    assign rdy[i] = !v_r || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[i]) begin
        v_r <= sv[i];
      end
      if (rdy[i] && sv[i]) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        a_r <= a_nxt;
        s_r <= ss[i];
      end
    end

    assign sv[i+1] = v_r;
    assign sx[i+1] = x_r;
    assign sy[i+1] = y_r;
    assign sa[i+1] = a_r;
    assign ss[i+1] = s_r;
  end

  assign in_ready  = rdy[0];
  assign out_valid = sv[NUM_STAGES];
  assign out_x     = sx[NUM_STAGES];
  assign out_y     = sy[NUM_STAGES];
  assign out_a     = sa[NUM_STAGES];
  assign out_side  = ss[NUM_STAGES];

endmodule

>>> rtl/pla_yaw.sv
// ----------------------------------------------------------------------------
// pla_yaw
// Yaw in tenths after the first pass; sets up the elevation pass.
// ----------------------------------------------------------------------------
module pla_yaw (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pla_pkg::vec_t   in_x,
  input  pla_pkg::angle_t in_a,
  input  pla_pkg::side_t  in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output pla_pkg::vec_t   out_x,
  output pla_pkg::vec_t   out_y,
  output pla_pkg::angle_t out_a,
  output pla_pkg::side_t  out_side
);
  import pla_pkg::*;

  logic  v_r;
  vec_t  x_r;
  side_t s_r;
  yaw_t  yaw_nxt;

  always_comb begin
    if (in_side.f.y_zero) begin
      yaw_nxt = in_side.f.x_neg ? signed'(YAW_LIMIT) : '0;
    end else if (in_side.f.x_zero) begin
      yaw_nxt = in_side.f.y_pos ? signed'(QUARTER) : -signed'(QUARTER);
    end else begin
      yaw_nxt = to_tenths(in_a, YAW_LIMIT);
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      x_r      <= in_x;
      s_r.f    <= in_side.f;
      s_r.gz   <= in_side.gz;
      s_r.yaw  <= yaw_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_x     = x_r;
  assign out_y     = s_r.gz;
  assign out_a     = '0;
  assign out_side  = s_r;

endmodule

>>> rtl/pla_pitch.sv
// ----------------------------------------------------------------------------
// pla_pitch
// Pitch in tenths after the second pass; holds the result register.
// ----------------------------------------------------------------------------
module pla_pitch (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pla_pkg::angle_t in_a,
  input  pla_pkg::side_t  in_side,
  output logic            out_valid,
  input  logic            out_ready,
  output pla_pkg::yaw_t   out_yaw,
  output pla_pkg::pitch_t out_pitch
);
  import pla_pkg::*;

  logic   v_r;
  yaw_t   yaw_r;
  pitch_t pitch_r;
  yaw_t   pitch_nxt;

  always_comb begin
    if (in_side.f.z_zero) begin
      pitch_nxt = '0;
    end else if (in_side.f.x_zero && in_side.f.y_zero) begin
      pitch_nxt = in_side.f.z_pos ? signed'(PITCH_LIMIT) : -signed'(PITCH_LIMIT);
    end else begin
      pitch_nxt = to_tenths(in_a, PITCH_LIMIT);
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      yaw_r   <= in_side.yaw;
      pitch_r <= pitch_nxt[PITCH_W-1:0];
    end
  end

  assign out_valid = v_r;
  assign out_yaw   = yaw_r;
  assign out_pitch = pitch_r;

endmodule

>>> rtl/point_look_angles.sv
// ----------------------------------------------------------------------------
// point_look_angles
// Look angles (yaw, pitch) of a 3-D point in tenths of a degree.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid/in_ready, in_point_x/y/z       | in
//   result  | out_valid/out_ready, out_yaw_tenths,    | out
//           | out_pitch_tenths                        |
//
// One point per cycle sustained while out_ready stays high. The pipeline is
// two front stages, one register per CORDIC iteration in each of the two
// vectoring passes, one yaw stage and the result register.
// Reset clears only the valid bits; there is no state between points.
// Each stage holds its transfer while the stage after it is full and
// stalled, so bubbles close up and a stall drops or repeats nothing.
//
module point_look_angles (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [15:0]           in_point_x,
  input  logic signed [15:0]           in_point_y,
  input  logic signed [15:0]           in_point_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [11:0]           out_yaw_tenths,
  output logic signed [10:0]           out_pitch_tenths
);
  import pla_pkg::*;

  // front -> first pass
  logic   f_valid, f_ready;
  vec_t   f_x, f_y;
  angle_t f_a;
  side_t  f_side;

  // first pass -> yaw stage
  logic   p1_valid, p1_ready;
  vec_t   p1_x;
  angle_t p1_a;
  side_t  p1_side;

  // yaw stage -> second pass
  logic   y_valid, y_ready;
  vec_t   y_x, y_y;
  angle_t y_a;
  side_t  y_side;

  // second pass -> pitch stage
  logic   p2_valid, p2_ready;
  angle_t p2_a;
  side_t  p2_side;

  // Fold the left half plane, flag the axes, scale z by the CORDIC gain.
  pla_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_point_x (unsigned'(in_point_x)),
    .in_point_y (unsigned'(in_point_y)),
    .in_point_z (unsigned'(in_point_z)),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_x      (f_x),
    .out_y      (f_y),
    .out_a      (f_a),
    .out_side   (f_side)
  );

  // Azimuth pass: leaves yaw in counts and the gain-scaled ground distance.
  pla_cordic_pass u_pass_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_x      (f_x),
    .in_y      (f_y),
    .in_a      (f_a),
    .in_side   (f_side),
    .out_valid (p1_valid),
    .out_ready (p1_ready),
    .out_x     (p1_x),
    .out_y     (),
    .out_a     (p1_a),
    .out_side  (p1_side)
  );

  // Convert yaw to tenths; start the elevation pass at (distance, z * K).
  pla_yaw u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p1_valid),
    .in_ready  (p1_ready),
    .in_x      (p1_x),
    .in_a      (p1_a),
    .in_side   (p1_side),
    .out_valid (y_valid),
    .out_ready (y_ready),
    .out_x     (y_x),
    .out_y     (y_y),
    .out_a     (y_a),
    .out_side  (y_side)
  );

  // Elevation pass.
  pla_cordic_pass u_pass_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (y_valid),
    .in_ready  (y_ready),
    .in_x      (y_x),
    .in_y      (y_y),
    .in_a      (y_a),
    .in_side   (y_side),
    .out_valid (p2_valid),
    .out_ready (p2_ready),
    .out_x     (),
    .out_y     (),
    .out_a     (p2_a),
    .out_side  (p2_side)
  );

  // Pitch in tenths and the result register.
  pla_pitch u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p2_valid),
    .in_ready  (p2_ready),
    .in_a      (p2_a),
    .in_side   (p2_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_yaw   (out_yaw_tenths),
    .out_pitch (out_pitch_tenths)
  );

endmodule
